### src/ifd_pkg.sv
// shared constants, types and helpers of the imu frame deframer
package ifd_pkg;

    localparam int FRAME_BYTES_DEF = 53;
    localparam int WORD_COUNT_DEF  = 12;

    localparam logic [7:0] SYNC_A = 8'hFA;
    localparam logic [7:0] SYNC_B = 8'hFF;
    localparam logic [7:0] SYNC_C = 8'h32;

    // running sum right after lock: sync bytes 1 and 2
    localparam logic [7:0] SUM_AT_LOCK = SYNC_B + SYNC_C;

    localparam int PAYLOAD_OFFSET = 4;

    // controller to datapath
    typedef struct packed {
        logic shift;    // hunting byte: slide window
        logic collect;  // frame byte: sum, count, store
        logic rd;       // read next payload word into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sync_hit;    // incoming byte completes the sync word
        logic frame_last;  // incoming byte is the last of the frame
        logic sum_zero;    // checksum including incoming byte is zero
        logic last_rd;     // read address is on the final word
        logic out_free;    // output register empty or being taken
    } t_sts;

    // y and z of accel, gyro and mag, then pitch and yaw
    function automatic logic axis_flipped(input logic [5:0] idx);
        logic flip;
        case (idx) inside
            6'd1, 6'd2, 6'd4, 6'd5, 6'd7, 6'd8, 6'd10, 6'd11: flip = 1'b1;
            default: flip = 1'b0;
        endcase
        return flip;
    endfunction

endpackage

### src/ifd_if.sv
// request channel interfaces: received bytes in, decoded words out
interface ifd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ifd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [31:0] word_value;
    logic        last_word;

    modport source (output valid, output word_index, output word_value,
                    output last_word, input ready);
    modport sink   (input valid, input word_index, input word_value,
                    input last_word, output ready);
endinterface

### src/ifd_ctrl.sv
// frame deframer controller: hunt, collect and drain sequencing
module ifd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ifd_pkg::t_sts i_sts,
    output ifd_pkg::t_cmd o_cmd
);
    import ifd_pkg::*;

    localparam logic [1:0] ST_HUNT    = 2'd0;
    localparam logic [1:0] ST_COLLECT = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready    = (r_state != ST_DRAIN);
    assign accept        = i_in_valid && o_in_ready;
    assign o_cmd.shift   = accept && (r_state == ST_HUNT);
    assign o_cmd.collect = accept && (r_state == ST_COLLECT);
    assign o_cmd.rd      = (r_state == ST_DRAIN) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_HUNT: begin
                if (o_cmd.shift && i_sts.sync_hit) n_state = ST_COLLECT;
            end
            ST_COLLECT: begin
                if (o_cmd.collect && i_sts.frame_last) begin
                    n_state = i_sts.sum_zero ? ST_DRAIN : ST_HUNT;
                end
            end
            ST_DRAIN: begin
                if (o_cmd.rd && i_sts.last_rd) n_state = ST_HUNT;
            end
            default: n_state = ST_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/ifd_dp.sv
// frame deframer datapath: sync window, count, checksum, payload store, output register
module ifd_dp #(
    parameter int FRAME_BYTES = ifd_pkg::FRAME_BYTES_DEF,
    parameter int WORD_COUNT  = ifd_pkg::WORD_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_rx_byte,
    input  ifd_pkg::t_cmd i_cmd,
    output ifd_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [3:0]    o_word_index,
    output logic [31:0]   o_word_value,
    output logic          o_last_word
);
    import ifd_pkg::*;

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int PAYLOAD_BYTES = 4 * WORD_COUNT;

    // two newest hunting bytes; the incoming byte completes the window
    logic [7:0]    r_win [1:2];
    logic [CW-1:0] r_count;
    logic [7:0]    r_sum;
    logic [7:0]    sum_next;
    logic [CW-1:0] off;
    logic          in_payload;
    logic [1:0]    wr_lane;
    logic [AW-1:0] wr_addr;

    logic [7:0]    r_mem [0:3][0:WORD_COUNT-1];
    logic [7:0]    r_rdata [0:3];
    logic [AW-1:0] r_rd_addr;
    logic          r_out_valid;
    logic          r_out_flip;
    logic [3:0]    r_out_idx;
    logic          r_out_last;

    assign sum_next   = r_sum + i_rx_byte;
    assign off        = r_count - CW'(PAYLOAD_OFFSET);
    assign in_payload = (32'(r_count) >= 32'(PAYLOAD_OFFSET))
                        && (32'(off) < 32'(PAYLOAD_BYTES));
    assign wr_lane    = off[1:0];
    assign wr_addr    = AW'(off >> 2);

    assign o_sts.sync_hit   = (r_win[1] == SYNC_A) && (r_win[2] == SYNC_B)
                              && (i_rx_byte == SYNC_C);
    assign o_sts.frame_last = ((r_count + CW'(1)) == CW'(FRAME_BYTES));
    assign o_sts.sum_zero   = (sum_next == 8'h00);
    assign o_sts.last_rd    = (r_rd_addr == AW'(WORD_COUNT - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // window, frame position and checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[1] <= 8'h00;
            r_win[2] <= 8'h00;
            r_count  <= '0;
            r_sum    <= 8'h00;
        end else if (i_cmd.shift) begin
            r_win[1] <= r_win[2];
            r_win[2] <= i_rx_byte;
            if (o_sts.sync_hit) begin
                r_count <= CW'(3);
                r_sum   <= SUM_AT_LOCK;
            end
        end else if (i_cmd.collect) begin
            if (o_sts.frame_last) begin
                r_count <= '0;
                r_sum   <= 8'h00;
            end else begin
                r_count <= r_count + CW'(1);
                r_sum   <= sum_next;
            end
        end
    end

    // payload store, one byte lane per position within a word
    always_ff @(posedge i_clk) begin
        if (i_cmd.collect && in_payload) begin
            r_mem[wr_lane][wr_addr] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            for (int i = 0; i < 4; i++) begin
                r_rdata[i] <= r_mem[i][r_rd_addr];
            end
            r_out_flip <= axis_flipped(6'(r_rd_addr));
            r_out_idx  <= 4'(r_rd_addr);
            r_out_last <= o_sts.last_rd;
        end
    end

    // drain address and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.collect && o_sts.frame_last) begin
                r_rd_addr <= '0;
            end else if (i_cmd.rd) begin
                r_rd_addr <= r_rd_addr + AW'(1);
            end
            if (o_sts.out_free) begin
                r_out_valid <= i_cmd.rd;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_word_index = r_out_idx;
    assign o_word_value = {r_rdata[0], r_rdata[1], r_rdata[2], r_rdata[3]}
                          ^ {r_out_flip, 31'd0};
    assign o_last_word  = r_out_last;

endmodule

### src/imu_frame_deframer.sv
// top level of the imu frame deframer: sync hunt, checksum and word drain
//
//  channel  dir  payload                               request moves
//  i_in     in   rx_byte[7:0]                          one serial byte
//  o_out    out  word_index[3:0] word_value[31:0]      one decoded word
//                last_word
//
// one byte per cycle while hunting or collecting a frame
// after the final byte of a good frame the input is held off while the WORD_COUNT
//   payload words leave through the store's read port, one word per cycle while the output takes them
// the last word may still wait at the output while the next byte is taken
// a stalled output only pauses the drain; nothing is dropped
// synchronous reset clears window, count, checksum and control; the payload
//   store needs no clearing pass
module imu_frame_deframer #(
    parameter int FRAME_BYTES = ifd_pkg::FRAME_BYTES_DEF,
    parameter int WORD_COUNT  = ifd_pkg::WORD_COUNT_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    ifd_in_if.sink    i_in,
    ifd_out_if.source o_out
);
    import ifd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: which phase a byte belongs to, when words are read out
    ifd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and arithmetic: window compare, running sum, byte lanes,
    // output register with axis sign flip
    ifd_dp #(
        .FRAME_BYTES (FRAME_BYTES),
        .WORD_COUNT  (WORD_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (i_in.rx_byte),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_word_index (o_out.word_index),
        .o_word_value (o_out.word_value),
        .o_last_word  (o_out.last_word)
    );

endmodule

### src/ifd_checker.sv
// port-level checks of the imu frame deframer and their binding
module ifd_checker #(
    parameter int WORD_COUNT = ifd_pkg::WORD_COUNT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_word_index,
    input logic [31:0] i_word_value,
    input logic        i_last_word
);
    import ifd_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable(i_word_value) && $stable(i_word_index)
            && $stable(i_last_word))
        else $error("stalled output word changed");

    // last word carries the final index
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last_word |-> i_word_index == 4'(WORD_COUNT - 1))
        else $error("last word on wrong index");

    // words of a frame follow each other without gaps
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_word |=> i_out_valid
            && i_word_index == $past(i_word_index) + 4'd1)
        else $error("drain gap or index skip");

    // a frame ends with an empty output
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_word |=> !i_out_valid)
        else $error("word after end of frame");

    // no byte is taken mid-drain
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last_word |-> !i_in_ready)
        else $error("input taken during drain");

endmodule

bind imu_frame_deframer ifd_checker #(.WORD_COUNT(WORD_COUNT)) u_ifd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_word_index (o_out.word_index),
    .i_word_value (o_out.word_value),
    .i_last_word  (o_out.last_word)
);
